### hdl/qhpm_pkg.sv
`timescale 1ns / 1ps
package qhpm_pkg;

    localparam int JOINTS_DEF = 32;

    localparam logic [19:0] MOVE_TICKS_RST = 20'd2000;
    localparam logic [24:0] MOVE_RECIP_RST = 25'd8389;
    localparam logic [23:0] VEL_SCALE_RST  = 24'd32768;
    localparam logic [22:0] POS_TOL_RST    = 23'd3277;
    localparam logic [22:0] VEL_TOL_RST    = 23'd6554;
    localparam logic [19:0] SETTLE_RST     = 20'd500;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 25;
    localparam logic [CFG_AW-1:0] REG_MOVE_TICKS = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MOVE_RECIP = 3'd1;
    localparam logic [CFG_AW-1:0] REG_VEL_SCALE  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_POS_TOL    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_VEL_TOL    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SETTLE     = 3'd5;

    localparam logic [1:0] CMD_ENTER = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_KEY   = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic signed [2:0] KEY_POLICY = 3'sd3;
    localparam logic signed [2:0] KEY_DAMP   = 3'sd1;
    localparam logic signed [2:0] KEY_OFF    = -3'sd1;

    localparam logic [1:0] MODE_STAY   = 2'd0;
    localparam logic [1:0] MODE_POLICY = 2'd1;
    localparam logic [1:0] MODE_DAMP   = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    // Input tdata from bit 0: joint_index, home position, measured position,
    // measured velocity, sample_valid, key. The command travels on tuser.
    localparam int IN_W = 88;
    localparam int OUT_W = 56;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_DEC, ST_S, ST_S2, ST_S3, ST_S4, ST_S5,
        ST_ALPHA, ST_ADOT, ST_TPOS, ST_TVEL, ST_OUT
    } state_t;

    // Datapath operation commanded by the controller in each state.
    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_S, OP_S2, OP_S3, OP_S4, OP_S5,
        OP_ALPHA, OP_ADOT, OP_TPOS, OP_TVEL, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_out;
    } ctl_t;

    typedef struct packed {
        logic quintic;   // item is a tick sample inside the move
    } sts_t;

endpackage

### hdl/qhpm_ram.sv
`timescale 1ns / 1ps
module qhpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/qhpm_ctrl.sv
`timescale 1ns / 1ps
module qhpm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  qhpm_pkg::sts_t  sts,
    input  logic            out_free,
    output logic            busy,
    output qhpm_pkg::ctl_t  ctl
);
    import qhpm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_RD;
            ST_RD:    state_next = ST_DEC;
            ST_DEC:   state_next = sts.quintic ? ST_S : ST_OUT;
            ST_S:     state_next = ST_S2;
            ST_S2:    state_next = ST_S3;
            ST_S3:    state_next = ST_S4;
            ST_S4:    state_next = ST_S5;
            ST_S5:    state_next = ST_ALPHA;
            ST_ALPHA: state_next = ST_ADOT;
            ST_ADOT:  state_next = ST_TPOS;
            ST_TPOS:  state_next = ST_TVEL;
            ST_TVEL:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.op = OP_NONE;
        ctl.load_out = 1'b0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_RD:    ctl.op = OP_NONE;
            ST_DEC:   ctl.op = OP_CAPTURE;
            ST_S:     ctl.op = OP_S;
            ST_S2:    ctl.op = OP_S2;
            ST_S3:    ctl.op = OP_S3;
            ST_S4:    ctl.op = OP_S4;
            ST_S5:    ctl.op = OP_S5;
            ST_ALPHA: ctl.op = OP_ALPHA;
            ST_ADOT:  ctl.op = OP_ADOT;
            ST_TPOS:  ctl.op = OP_TPOS;
            ST_TVEL:  ctl.op = OP_TVEL;
            ST_OUT: begin
                if (out_free) begin
                    ctl.op = OP_FINISH;
                    ctl.load_out = 1'b1;
                end
            end
            default: busy = 1'b1;
        endcase
    end
endmodule

### hdl/qhpm_dp.sv
`timescale 1ns / 1ps
module qhpm_dp #(
    parameter int JOINTS = qhpm_pkg::JOINTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [qhpm_pkg::IN_W-1:0]   in_data,
    input  logic [1:0]                  in_user,
    input  logic                        in_last,
    input  logic                        cfg_we,
    input  logic [qhpm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [qhpm_pkg::CFG_DW-1:0] cfg_wdata,
    input  qhpm_pkg::ctl_t              ctl,
    output qhpm_pkg::sts_t              sts,
    output logic [qhpm_pkg::OUT_W-1:0]  res_data
);
    import qhpm_pkg::*;

    localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic signed [25:0] ONE = 26'sd16777216;

    // configuration
    logic [19:0] move_ticks_reg, settle_ticks_reg;
    logic [24:0] move_recip_reg;
    logic [23:0] vel_scale_reg;
    logic [22:0] pos_tol_reg, vel_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_ticks_reg   <= MOVE_TICKS_RST;
            move_recip_reg   <= MOVE_RECIP_RST;
            vel_scale_reg    <= VEL_SCALE_RST;
            pos_tol_reg      <= POS_TOL_RST;
            vel_tol_reg      <= VEL_TOL_RST;
            settle_ticks_reg <= SETTLE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MOVE_TICKS: move_ticks_reg   <= cfg_wdata[19:0];
                REG_MOVE_RECIP: move_recip_reg   <= cfg_wdata[24:0];
                REG_VEL_SCALE:  vel_scale_reg    <= cfg_wdata[23:0];
                REG_POS_TOL:    pos_tol_reg      <= cfg_wdata[22:0];
                REG_VEL_TOL:    vel_tol_reg      <= cfg_wdata[22:0];
                REG_SETTLE:     settle_ticks_reg <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0]         cmd_reg;
    logic [4:0]         idx_reg;
    logic signed [23:0] home_reg, jpos_reg, jvel_reg;
    logic               valid_reg, last_reg;
    logic signed [2:0]  key_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg   <= in_user;
            idx_reg   <= in_data[4:0];
            home_reg  <= in_data[28:5];
            jpos_reg  <= in_data[52:29];
            jvel_reg  <= in_data[76:53];
            valid_reg <= in_data[77];
            key_reg   <= in_data[80:78];
            last_reg  <= in_last;
        end
    end

    logic idx_ok;
    assign idx_ok = ({27'd0, idx_reg} < 32'(JOINTS));

    logic [IW-1:0] ram_addr;
    logic [23:0]   ram_rdata;
    assign ram_addr = IW'(idx_reg);

    qhpm_ram #(.WIDTH(24), .DEPTH(JOINTS)) u_start_ram (
        .aclk  (aclk),
        .we    (ctl.op == OP_FINISH && cmd_reg == CMD_ENTER && idx_ok),
        .waddr (ram_addr),
        .wdata (jpos_reg),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // tick state
    logic [19:0] tick_reg, settle_reg;
    logic        ready_reg, allv_reg;
    logic [23:0] perr_reg, pspd_reg;

    assign sts.quintic = (cmd_reg == CMD_TICK) && (tick_reg < move_ticks_reg);

    // shared multiplier datapath
    logic signed [24:0] d_reg;       // home - start
    logic signed [23:0] start_reg;
    logic [24:0]        s_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [24:0]        alpha_reg;
    logic signed [28:0] prof_reg;
    logic signed [28:0] acc_reg;     // velocity rate, below 2^25
    logic signed [23:0] tpos_reg, tvel_reg;

    logic signed [28:0] ma;
    logic signed [25:0] mb;
    logic signed [54:0] prod;
    logic [5:0]         sh;

    always_comb begin
        ma = '0;
        mb = '0;
        sh = 6'd24;
        unique case (ctl.op)
            OP_S: begin
                ma = {9'd0, tick_reg};
                mb = {1'b0, move_recip_reg};
                sh = 6'd0;
            end
            OP_S2:  begin ma = {4'd0, s_reg};  mb = {1'b0, s_reg}; end
            OP_S3:  begin ma = {4'd0, s2_reg}; mb = {1'b0, s_reg}; end
            OP_S4:  begin ma = {4'd0, s3_reg}; mb = {1'b0, s_reg}; end
            OP_S5:  begin ma = {4'd0, s4_reg}; mb = {1'b0, s_reg}; end
            OP_ADOT: begin ma = prof_reg; mb = {2'd0, vel_scale_reg}; end
            OP_TPOS: begin ma = {4'd0, alpha_reg}; mb = {d_reg[24], d_reg}; end
            OP_TVEL: begin
                ma = acc_reg;
                mb = {d_reg[24], d_reg};
                sh = 6'd16;
            end
            default: ;
        endcase
    end

    assign prod = 55'(ma) * 55'(mb);

    // round half up: floor((x + 2^(sh-1)) >> sh), arithmetic shift
    logic signed [54:0] rnd;
    always_comb begin
        if (sh == 6'd0) rnd = prod;
        else rnd = (prod + (55'sd1 <<< (sh - 6'd1))) >>> sh;
    end

    function automatic logic signed [23:0] sat24(input logic signed [54:0] x);
        if (x > 55'sd8388607) return 24'sh7FFFFF;
        if (x < -55'sd8388608) return 24'sh800000;
        return x[23:0];
    endfunction

    logic signed [29:0] alpha_raw, prof_raw;
    assign alpha_raw = 30'sd10 * $signed({5'd0, s3_reg}) - 30'sd15 * $signed({5'd0, s4_reg})
                     + 30'sd6 * $signed({5'd0, s5_reg});
    assign prof_raw  = 30'sd30 * $signed({5'd0, s2_reg}) - 30'sd60 * $signed({5'd0, s3_reg})
                     + 30'sd30 * $signed({5'd0, s4_reg});

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            OP_CAPTURE: begin
                start_reg <= idx_ok ? $signed(ram_rdata) : 24'sd0;
                d_reg <= 25'(home_reg) - (idx_ok ? 25'($signed(ram_rdata)) : 25'sd0);
            end
            OP_S:  s_reg  <= (rnd > 55'(ONE)) ? 25'(ONE) : rnd[24:0];
            OP_S2: s2_reg <= rnd[24:0];
            OP_S3: s3_reg <= rnd[24:0];
            OP_S4: s4_reg <= rnd[24:0];
            OP_S5: s5_reg <= rnd[24:0];
            OP_ALPHA: begin
                if (alpha_raw < 0) alpha_reg <= '0;
                else if (alpha_raw > 30'(ONE)) alpha_reg <= 25'(ONE);
                else alpha_reg <= alpha_raw[24:0];
            end
            OP_ADOT: acc_reg <= rnd[28:0];
            OP_TPOS: tpos_reg <= sat24(rnd + 55'(start_reg));
            OP_TVEL: tvel_reg <= sat24(rnd);
            default: ;
        endcase
        if (ctl.op == OP_ALPHA) begin
            prof_reg <= (prof_raw < 0) ? 29'sd0 : prof_raw[28:0];
        end
    end

    // tick bookkeeping and result assembly
    logic [24:0] err_abs;
    logic [23:0] err_sat, vabs;
    logic signed [24:0] err_s;
    assign err_s   = 25'(home_reg) - 25'(jpos_reg);
    assign err_abs = err_s[24] ? 25'(-err_s) : 25'(err_s);
    assign err_sat = err_abs[24] ? 24'hFFFFFF : err_abs[23:0];
    assign vabs    = jvel_reg[23] ? 24'(-25'(jvel_reg)) : 24'(jvel_reg);

    logic [23:0] perr_n, pspd_n;
    logic        allv_n, conv;
    logic [19:0] settle_n;
    assign perr_n = (err_sat > perr_reg) ? err_sat : perr_reg;
    assign pspd_n = (vabs > pspd_reg) ? vabs : pspd_reg;
    assign allv_n = allv_reg & valid_reg;
    assign conv   = allv_n && perr_n <= {1'b0, pos_tol_reg} && pspd_n <= {1'b0, vel_tol_reg};
    assign settle_n = !conv ? 20'd0 : (settle_reg != 20'hFFFFF ? settle_reg + 20'd1 : settle_reg);

    logic signed [23:0] o_tpos, o_tvel;
    logic [1:0]         o_mode;
    logic               o_blk, o_ready;

    always_comb begin
        o_tpos = '0;
        o_tvel = '0;
        o_mode = MODE_STAY;
        o_blk  = 1'b0;
        o_ready = ready_reg;
        case (cmd_reg)
            CMD_ENTER: begin
                o_tpos = jpos_reg;
                o_ready = 1'b0;
            end
            CMD_TICK: begin
                if (sts.quintic) begin
                    o_tpos = tpos_reg;
                    o_tvel = tvel_reg;
                end else begin
                    o_tpos = home_reg;
                    if (last_reg && !ready_reg && settle_n >= settle_ticks_reg) o_ready = 1'b1;
                end
            end
            CMD_KEY: begin
                if (key_reg == KEY_POLICY) begin
                    if (ready_reg) o_mode = MODE_POLICY;
                    else o_blk = 1'b1;
                end else if (key_reg == KEY_DAMP) begin
                    o_mode = MODE_DAMP;
                end else if (key_reg == KEY_OFF) begin
                    o_mode = MODE_OFF;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            settle_reg <= '0;
            ready_reg <= 1'b0;
            perr_reg <= '0;
            pspd_reg <= '0;
            allv_reg <= 1'b1;
        end else if (ctl.op == OP_FINISH) begin
            if (cmd_reg == CMD_ENTER) begin
                tick_reg <= '0;
                settle_reg <= '0;
                ready_reg <= 1'b0;
                perr_reg <= '0;
                pspd_reg <= '0;
                allv_reg <= 1'b1;
            end else if (cmd_reg == CMD_TICK) begin
                ready_reg <= o_ready;
                if (!sts.quintic) begin
                    perr_reg <= perr_n;
                    pspd_reg <= pspd_n;
                    allv_reg <= allv_n;
                    if (last_reg && !ready_reg) settle_reg <= settle_n;
                end
                if (last_reg) begin
                    perr_reg <= '0;
                    pspd_reg <= '0;
                    allv_reg <= 1'b1;
                    if (tick_reg != 20'hFFFFF) tick_reg <= tick_reg + 20'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            res_data <= {4'd0, o_blk, o_mode, o_ready, o_tvel, o_tpos};
        end
    end
endmodule

### hdl/quintic_home_pose_mover_core.sv
`timescale 1ns / 1ps
// Quintic home-pose mover: one result transaction per input transaction.
// Enter, key, unused and post-move tick items pass through read, capture and output states;
// a tick sample inside the move also steps the one shared multiplier through s..s^5,
// the velocity rate and both targets at one product per cycle.
// Items are taken one at a time: a new one is accepted only after the last leaves its output state.
// Reset (aresetn low, synchronous) restores register defaults and clears counters.
module quintic_home_pose_mover_core #(
    parameter int JOINTS = qhpm_pkg::JOINTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // joint_index, home position, measured position, measured velocity, sample_valid,
    // key, zero pad
    input  logic [qhpm_pkg::IN_W-1:0]   s_tdata,
    // command
    input  logic [1:0]                  s_tuser,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // commanded position, commanded velocity, ready_res, next_mode, blocked, zero pad
    output logic [qhpm_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [qhpm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [qhpm_pkg::CFG_DW-1:0] cfg_wdata
);
    import qhpm_pkg::*;

    logic busy, start, out_free, m_tvalid_reg;
    ctl_t ctl;
    sts_t sts;

    // The controller takes a transaction only when idle; the output register
    // holds a finished result until the downstream side accepts it. While a
    // result waits, the next item runs up to its final state and holds there.
    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    qhpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .sts      (sts),
        .out_free (out_free),
        .busy     (busy),
        .ctl      (ctl)
    );

    qhpm_dp #(.JOINTS(JOINTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .res_data  (m_tdata)
    );
endmodule

### tb/qhpm_checker.sv
`timescale 1ns / 1ps
// Watches both streams and the register port of the home-pose mover, keeps its
// own copy of the joint state and settings, and compares every result field.
module qhpm_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [qhpm_pkg::IN_W-1:0]   s_tdata,
    input  logic [1:0]                  s_tuser,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [qhpm_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [qhpm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [qhpm_pkg::CFG_DW-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          pending,
    output int                          checked
);
    import qhpm_pkg::*;

    localparam longint Q24_ONE = 64'sd1 << 24;

    logic [19:0] move_len;
    logic [24:0] move_inv;
    logic [23:0] rate_scale;
    logic [22:0] pos_tol;
    logic [22:0] vel_tol;
    logic [19:0] settle_need;

    logic signed [23:0] start_at [32];
    logic [19:0] tick_no;
    logic [19:0] settled_ticks;
    logic        pose_ready;
    longint      worst_err;
    longint      worst_speed;
    logic        all_valid;

    logic [OUT_W-1:0] pose_results [$];

    function automatic longint round_shift(longint x, int sh);
        return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip24(longint x);
        return x > 8388607 ? 8388607 : (x < -8388608 ? -8388608 : x);
    endfunction

    // Advances the joint state by one item and returns the packed result.
    function automatic logic [OUT_W-1:0] advance_pose(logic [IN_W-1:0] d, logic [1:0] cmd,
                                                      logic last);
        logic [4:0]         idx;
        logic signed [23:0] home, jpos, jvel;
        logic               ok;
        logic signed [2:0]  key;
        longint span, s, s2, s3, s4, s5, alpha, prof, adot, e, v, tpos, tvel;
        logic [1:0] mode;
        logic       blk;
        logic       conv;
        idx  = d[4:0];
        home = d[28:5];
        jpos = d[52:29];
        jvel = d[76:53];
        ok   = d[77];
        key  = d[80:78];
        tpos = 0;
        tvel = 0;
        mode = MODE_STAY;
        blk  = 1'b0;
        if (cmd == CMD_ENTER) begin
            start_at[idx] = jpos;
            tick_no = '0;
            settled_ticks = '0;
            pose_ready = 1'b0;
            worst_err = 0;
            worst_speed = 0;
            all_valid = 1'b1;
            tpos = jpos;
        end else if (cmd == CMD_TICK) begin
            span = longint'(home) - longint'(start_at[idx]);
            if (tick_no < move_len) begin
                s = longint'(tick_no) * longint'(move_inv);
                if (s > Q24_ONE) s = Q24_ONE;
                s2 = round_shift(s * s, 24);
                s3 = round_shift(s2 * s, 24);
                s4 = round_shift(s3 * s, 24);
                s5 = round_shift(s4 * s, 24);
                alpha = 10 * s3 - 15 * s4 + 6 * s5;
                if (alpha < 0) alpha = 0;
                if (alpha > Q24_ONE) alpha = Q24_ONE;
                prof = 30 * s2 - 60 * s3 + 30 * s4;
                if (prof < 0) prof = 0;
                adot = round_shift(prof * longint'(rate_scale), 24);
                tpos = clip24(longint'(start_at[idx]) + round_shift(alpha * span, 24));
                tvel = clip24(round_shift(adot * span, 16));
            end else begin
                e = longint'(home) - longint'(jpos);
                if (e < 0) e = -e;
                if (e > 64'hFFFFFF) e = 64'hFFFFFF;
                v = longint'(jvel);
                if (v < 0) v = -v;
                tpos = home;
                if (e > worst_err) worst_err = e;
                if (v > worst_speed) worst_speed = v;
                if (!ok) all_valid = 1'b0;
                if (last && !pose_ready) begin
                    conv = all_valid && worst_err <= longint'(pos_tol)
                           && worst_speed <= longint'(vel_tol);
                    if (!conv) settled_ticks = '0;
                    else if (settled_ticks != 20'hFFFFF) settled_ticks++;
                    if (settled_ticks >= settle_need) pose_ready = 1'b1;
                end
            end
            if (last) begin
                worst_err = 0;
                worst_speed = 0;
                all_valid = 1'b1;
                if (tick_no != 20'hFFFFF) tick_no++;
            end
        end else if (cmd == CMD_KEY) begin
            if (key == KEY_POLICY) begin
                if (pose_ready) mode = MODE_POLICY;
                else blk = 1'b1;
            end else if (key == KEY_DAMP) begin
                mode = MODE_DAMP;
            end else if (key == KEY_OFF) begin
                mode = MODE_OFF;
            end
        end
        return {4'b0, blk, mode, pose_ready, tvel[23:0], tpos[23:0]};
    endfunction

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            move_len = MOVE_TICKS_RST;
            move_inv = MOVE_RECIP_RST;
            rate_scale = VEL_SCALE_RST;
            pos_tol = POS_TOL_RST;
            vel_tol = VEL_TOL_RST;
            settle_need = SETTLE_RST;
            tick_no = '0;
            settled_ticks = '0;
            pose_ready = 1'b0;
            worst_err = 0;
            worst_speed = 0;
            all_valid = 1'b1;
            foreach (start_at[i]) start_at[i] = '0;
            pose_results.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MOVE_TICKS: move_len = cfg_wdata[19:0];
                    REG_MOVE_RECIP: move_inv = cfg_wdata[24:0];
                    REG_VEL_SCALE:  rate_scale = cfg_wdata[23:0];
                    REG_POS_TOL:    pos_tol = cfg_wdata[22:0];
                    REG_VEL_TOL:    vel_tol = cfg_wdata[22:0];
                    REG_SETTLE:     settle_need = cfg_wdata[19:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pose_results.push_back(advance_pose(s_tdata, s_tuser, s_tlast));
            if (m_tvalid && m_tready) begin
                if (pose_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pose_results.pop_front();
                    checked++;
                    if (want[23:0] !== m_tdata[23:0]) begin
                        $error("cmd_pos expected %h got %h", want[23:0], m_tdata[23:0]);
                        fail_count++;
                    end
                    if (want[47:24] !== m_tdata[47:24]) begin
                        $error("cmd_vel expected %h got %h", want[47:24], m_tdata[47:24]);
                        fail_count++;
                    end
                    if (want[48] !== m_tdata[48]) begin
                        $error("ready_res expected %b got %b", want[48], m_tdata[48]);
                        fail_count++;
                    end
                    if (want[50:49] !== m_tdata[50:49]) begin
                        $error("next_mode expected %0d got %0d", want[50:49], m_tdata[50:49]);
                        fail_count++;
                    end
                    if (want[51] !== m_tdata[51]) begin
                        $error("blocked expected %b got %b", want[51], m_tdata[51]);
                        fail_count++;
                    end
                end
            end
        end
        pending = pose_results.size();
    end

endmodule

### tb/tb_quintic_home_pose_mover_core.sv
`timescale 1ns / 1ps
// Top of the home-pose mover bench. It builds the stimulus, paces both stream
// sides, writes the registers between phases and gives the verdict; all
// prediction and comparison lives in the checker instance.
module tb_quintic_home_pose_mover_core;
    import qhpm_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    int fail_count, pending, checked;

    // Joints whose start position has been captured, and their home poses.
    logic               entered [32];
    logic signed [23:0] home_of [32];
    int                 burst_left = 0;
    int                 hold_asks = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 rx_cycle = 0;
    int                 phases_run = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quintic_home_pose_mover_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    qhpm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // The receiver stalls on a slowly rotating pattern: always ready, a coin
    // toss, and mostly ready with rare stalls. A requested hold-off keeps it
    // stalled for a long stretch so the block backs up into its input side.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= 300;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle >> 7) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Offers one transaction, called at a rising edge and returning at the
    // edge where it was accepted. The sender works in bursts with idle gaps;
    // some bursts are long enough to give stretches without any idling.
    task automatic send_item(logic [1:0] cmd, logic [4:0] idx, logic [23:0] home,
                             logic [23:0] pos, logic [23:0] vel, logic ok,
                             logic last, logic [2:0] key);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, key, ok, vel, pos, home, idx};
        s_tlast  <= last;
        if (cmd == CMD_ENTER) begin
            entered[idx] = 1'b1;
        end
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Stops offering and waits until every expected result has arrived, plus
    // a margin for the longest item latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic program_move(logic [19:0] ticks, logic [24:0] recip, logic [23:0] vscale,
                                logic [22:0] ptol, logic [22:0] vtol, logic [19:0] settle);
        drain();
        write_reg(REG_MOVE_TICKS, CFG_DW'(ticks));
        write_reg(REG_MOVE_RECIP, recip);
        write_reg(REG_VEL_SCALE, CFG_DW'(vscale));
        write_reg(REG_POS_TOL, CFG_DW'(ptol));
        write_reg(REG_VEL_TOL, CFG_DW'(vtol));
        write_reg(REG_SETTLE, CFG_DW'(settle));
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    function automatic logic [23:0] rand_pose();
        if ($urandom_range(0, 3) == 0) return 24'($urandom());
        return 24'($urandom_range(0, 2097152) - 1048576);
    endfunction

    // One homing run: capture a few joints, then stream whole control ticks in
    // which the measured pose mostly sits near home, with occasional invalid
    // samples, large errors and operator keys mixed between joints.
    task automatic homing_run(int n_joints, int n_ticks, int err_span);
        logic [4:0]  first;
        logic [4:0]  j;
        logic [23:0] pos;
        first = 5'($urandom());
        for (int i = 0; i < n_joints; i++) begin
            j = first + 5'(i);
            home_of[j] = rand_pose();
            send_item(CMD_ENTER, j, 24'($urandom()), rand_pose(), 24'($urandom()),
                      1'($urandom()), 1'b0, 3'($urandom()));
        end
        for (int t = 0; t < n_ticks; t++) begin
            for (int i = 0; i < n_joints; i++) begin
                j = first + 5'(i);
                pos = 24'(home_of[j] + $urandom_range(0, 2 * err_span) - err_span);
                if ($urandom_range(0, 49) == 0) pos = 24'($urandom());
                send_item(CMD_TICK, j, home_of[j], pos,
                          24'($urandom_range(0, 2 * err_span) - err_span),
                          $urandom_range(0, 39) != 0, i == n_joints - 1, 3'($urandom()));
                if ($urandom_range(0, 15) == 0)
                    send_item(CMD_KEY, 5'($urandom()), 24'($urandom()), 24'($urandom()),
                              24'($urandom()), 1'($urandom()), 1'($urandom()),
                              3'($urandom()));
            end
        end
        send_item(CMD_KEY, j, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0, KEY_POLICY);
    endtask

    // Items that only stir the inputs: the unused command and ticks of joints
    // already captured, with fully random fields.
    task automatic noise_items(int count);
        logic [4:0] j;
        for (int i = 0; i < count; i++) begin
            j = 5'($urandom());
            if (entered[j] && $urandom_range(0, 1))
                send_item(CMD_TICK, j, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                          1'($urandom()), 1'($urandom()), 3'($urandom()));
            else
                send_item(CMD_SPARE, 5'($urandom()), 24'($urandom()), 24'($urandom()),
                          24'($urandom()), 1'($urandom()), 1'($urandom()),
                          3'($urandom()));
        end
    endtask

    task automatic random_phase(int items, int n_max, int err_span);
        int start;
        start = checked + pending;
        while (checked + pending - start < items) begin
            if ($urandom_range(0, 7) == 0)
                noise_items($urandom_range(1, 6));
            else
                homing_run($urandom_range(1, n_max), $urandom_range(1, 12), err_span);
        end
    endtask

    initial begin
        foreach (entered[i]) entered[i] = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under reset settings: extreme start and home poses,
        // every key code and the unused command.
        send_item(CMD_ENTER, 5'd0, 24'h000000, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0, 3'd0);
        send_item(CMD_ENTER, 5'd31, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 3'd7);
        send_item(CMD_TICK, 5'd0, 24'h7FFFFF, 24'h000000, 24'h000000, 1'b1, 1'b0, 3'd0);
        send_item(CMD_TICK, 5'd31, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 3'd0);
        for (int k = 0; k < 8; k++)
            send_item(CMD_KEY, 5'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 3'(k));
        send_item(CMD_SPARE, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 3'd7);

        // Very short move: once settled, a policy request goes through.
        program_move(20'd1, 25'd16777216, 24'hFFFFFF, 23'd3277, 23'd6554, 20'd0);
        send_item(CMD_ENTER, 5'd3, 24'd0, 24'h7FFFFF, 24'd0, 1'b1, 1'b0, 3'd0);
        send_item(CMD_TICK, 5'd3, 24'h800000, 24'h800000, 24'd0, 1'b1, 1'b1, 3'd0);
        send_item(CMD_TICK, 5'd3, 24'd100, 24'd100, 24'd0, 1'b1, 1'b1, 3'd0);
        send_item(CMD_KEY, 5'd3, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0, KEY_POLICY);

        program_move(20'd4, 25'd4194304, 24'd1677722, 23'd3277, 23'd6554, 20'd2);
        random_phase(250, 6, 4000);

        // Long receiver hold-off while the sender keeps offering items.
        hold_asks <= hold_asks + 1;
        random_phase(60, 4, 4000);

        program_move(20'd0, 25'd0, 24'd0, 23'd0, 23'd0, 20'd0);
        random_phase(200, 8, 2);

        program_move(20'hFFFFF, 25'd16777216, 24'hFFFFFF, 23'h7FFFFF, 23'h7FFFFF, 20'hFFFFF);
        random_phase(250, 8, 1 << 20);

        program_move(20'd10, 25'd1677722, 24'd3355443, 23'd2000, 23'd3000, 20'd3);
        random_phase(260, 6, 2500);

        // Short move whose reciprocal overshoots, so s clamps before the end.
        program_move(20'd8, 25'd5000000, 24'd8388608, 23'h7FFFFF, 23'h7FFFFF, 20'd1);
        random_phase(260, 5, 5000);

        drain();
        $display("Checked %0d result transactions over %0d register settings,", checked,
                 phases_run + 1);
        $display("covering capture, quintic move, settling, operator keys and idle items.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

### quintic_home_pose_mover_core.f
hdl/qhpm_pkg.sv
hdl/qhpm_ram.sv
hdl/qhpm_ctrl.sv
hdl/qhpm_dp.sv
hdl/quintic_home_pose_mover_core.sv
tb/qhpm_checker.sv
tb/tb_quintic_home_pose_mover_core.sv
